// ===== rtl/xrr_pkg.sv =====
// Shared types, constants and the xor-shift step function for the
// xorshift range random core. No dependencies.
`timescale 1ns / 1ps

package xrr_pkg;

	localparam int WORD_W      = 64;
	localparam int STEP_N      = 7;
	localparam int STEP_W      = $clog2(STEP_N);
	localparam int DIV_CNT_W   = $clog2(WORD_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t SEED_RESET = WORD_W'(1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_N - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

	// How the back end builds the result
	typedef enum logic [1:0] {
		KIND_MOD,   // lo + state mod span
		KIND_BOUND, // equal bounds: the bound itself
		KIND_RAW    // span wrapped to zero: raw state
	} kind_t;

	typedef struct packed {
		kind_t kind;
		word_t lo;
		word_t span;
		word_t state;
	} job_t;

	// One of the seven xor-shift steps of an advance
	function automatic word_t xs_step(word_t s, logic [STEP_W-1:0] idx);
		word_t r;
		case (idx)
			3'd0: r = s ^ (s >> 5);
			3'd1: r = s ^ (s << 10);
			3'd2: r = s ^ (s >> 17);
			3'd3: r = s ^ (s << 3);
			3'd4: r = s ^ (s >> 12);
			3'd5: r = s ^ (s << 9);
			3'd6: r = s ^ (s >> 8);
			default: r = s;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/xrr_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on xrr_pkg.
`timescale 1ns / 1ps

interface xrr_req_if;
	import xrr_pkg::*;
	logic  valid;
	logic  ready;
	word_t low_bound;
	word_t high_bound;

	modport source (output valid, output low_bound, output high_bound, input ready);
	modport sink   (input valid, input low_bound, input high_bound, output ready);
endinterface

interface xrr_rsp_if;
	import xrr_pkg::*;
	logic  valid;
	logic  ready;
	word_t random_value;

	modport source (output valid, output random_value, input ready);
	modport sink   (input valid, input random_value, output ready);
endinterface

// ===== rtl/xrr_front.sv =====
// Front end: takes request beats, orders the bounds, advances the generator
// one xor-shift step per cycle and hands a job to the queue. Uses xrr_pkg, xrr_if.
`timescale 1ns / 1ps

module xrr_front (
	input  logic          clk,
	input  logic          arst_n,
	xrr_req_if.sink       req,
	input  logic          cfg_we,
	input  xrr_pkg::word_t cfg_wdata,
	output logic          job_valid,
	output xrr_pkg::job_t job,
	input  logic          job_ready
);
	import xrr_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_CLASS, F_STEP, F_PUSH} fstate_t;

	fstate_t           fstate_q;
	word_t             seed_q;
	word_t             gen_q;
	logic              seeded_q;
	word_t             lo_q;
	word_t             hi_q;
	logic              equal_q;
	logic [1:0]        adv_q;
	logic [STEP_W-1:0] step_q;

	logic  swapped;
	word_t span;

	assign swapped = lo_q > hi_q;
	assign span    = hi_q - lo_q + WORD_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q <= F_IDLE;
			seed_q   <= SEED_RESET;
			gen_q    <= '0;
			seeded_q <= 1'b0;
			lo_q     <= '0;
			hi_q     <= '0;
			equal_q  <= 1'b0;
			adv_q    <= '0;
			step_q   <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			case (fstate_q)
				F_IDLE: begin
					if (req.valid) begin
						lo_q     <= req.low_bound;
						hi_q     <= req.high_bound;
						fstate_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					equal_q <= (lo_q == hi_q);
					step_q  <= '0;
					if (swapped) begin
						lo_q <= hi_q;
						hi_q <= lo_q;
					end
					// first advance after reset is a plain seed load
					if (!seeded_q) begin
						gen_q    <= seed_q;
						seeded_q <= 1'b1;
						adv_q    <= swapped ? 2'd1 : 2'd0;
						fstate_q <= swapped ? F_STEP : F_PUSH;
					end else begin
						adv_q    <= swapped ? 2'd2 : 2'd1;
						fstate_q <= F_STEP;
					end
				end
				F_STEP: begin
					gen_q <= xs_step(gen_q, step_q);
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						adv_q  <= adv_q - 2'd1;
						if (adv_q == 2'd1) begin
							fstate_q <= F_PUSH;
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						fstate_q <= F_IDLE;
					end
				end
				default: fstate_q <= F_IDLE;
			endcase
		end
	end

	assign req.ready = (fstate_q == F_IDLE);
	assign job_valid = (fstate_q == F_PUSH);

	always_comb begin
		job.lo    = lo_q;
		job.span  = span;
		job.state = gen_q;
		if (equal_q) begin
			job.kind = KIND_BOUND;
		end else if (span == '0) begin
			job.kind = KIND_RAW;
		end else begin
			job.kind = KIND_MOD;
		end
	end

endmodule

// ===== rtl/xrr_queue.sv =====
// Two-entry job queue between front and back ends.
// Uses xrr_pkg.
`timescale 1ns / 1ps

module xrr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  xrr_pkg::job_t in_job,
	output logic          out_valid,
	input  logic          out_ready,
	output xrr_pkg::job_t out_job
);
	import xrr_pkg::*;

	job_t                slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;

	logic push;
	logic pop;

	assign in_ready  = (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_job   = slots_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

// ===== rtl/xrr_back.sv =====
// Back end: radix-2 restoring remainder, one bit per cycle, then the
// final add into the range and the output register. Uses xrr_pkg, xrr_if.
`timescale 1ns / 1ps

module xrr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  xrr_pkg::job_t job,
	xrr_rsp_if.source     rsp
);
	import xrr_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} bstate_t;

	bstate_t              bstate_q;
	word_t                lo_q;
	word_t                span_q;
	word_t                num_q;
	logic [WORD_W:0]      rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	word_t                out_data_q;

	logic [WORD_W:0] rem_sh;
	logic            fits;
	word_t           sum;
	logic            out_load;

	assign rem_sh = {rem_q[WORD_W-1:0], num_q[WORD_W-1]};
	assign fits   = (rem_sh >= {1'b0, span_q});
	assign sum    = lo_q + rem_q[WORD_W-1:0];

	// result register is free or empties this cycle
	assign out_load = (bstate_q == B_DONE) && (!out_valid_q || rsp.ready);

	assign job_ready        = (bstate_q == B_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= B_IDLE;
			lo_q        <= '0;
			span_q      <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_data_q  <= sum;
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (bstate_q)
				B_IDLE: begin
					if (job_valid) begin
						cnt_q <= '0;
						case (job.kind)
							KIND_BOUND: begin
								lo_q     <= job.lo;
								rem_q    <= '0;
								bstate_q <= B_DONE;
							end
							KIND_RAW: begin
								lo_q     <= '0;
								rem_q    <= {1'b0, job.state};
								bstate_q <= B_DONE;
							end
							default: begin
								lo_q     <= job.lo;
								span_q   <= job.span;
								num_q    <= job.state;
								rem_q    <= '0;
								bstate_q <= B_DIV;
							end
						endcase
					end
				end
				B_DIV: begin
					rem_q <= fits ? (rem_sh - {1'b0, span_q}) : rem_sh;
					num_q <= num_q << 1;
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_LAST) begin
						bstate_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_load) begin
						bstate_q <= B_IDLE;
					end
				end
				default: bstate_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/xorshift_range_random_core.sv =====
// Top level of the xorshift range random core: front end, job queue and
// remainder back end. Uses xrr_pkg, xrr_if, xrr_front, xrr_queue, xrr_back.
`timescale 1ns / 1ps

// Each request beat carries two 64-bit bounds in either order and yields one
// result beat holding a pseudo-random value in the inclusive range between
// them. The generator state is loaded from the seed register by the first
// request after reset; every later advance runs seven xor-shift steps, one
// per cycle. Swapped bounds advance the generator twice, equal bounds return
// the bound, and the full 64-bit range returns the raw state. A seed write
// only matters before the first request after reset. The front end steps
// the generator for each request and queues up to two jobs ahead of the
// back end, which runs the one-bit-per-cycle restoring remainder for a
// ranged result and skips it for equal bounds or the full range. Each end
// takes a new request or job only once it has handed on the last one, so
// sustained throughput of ranged results is set by the remainder loop.

module xorshift_range_random_core (
	input  logic           clk,
	input  logic           arst_n,
	xrr_req_if.sink        req,
	xrr_rsp_if.source      rsp,
	input  logic           cfg_we,
	input  xrr_pkg::word_t cfg_wdata
);
	import xrr_pkg::*;

	// front end to queue
	logic f_job_valid;
	logic f_job_ready;
	job_t f_job;

	// queue to back end
	logic b_job_valid;
	logic b_job_ready;
	job_t b_job;

	xrr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job_valid (f_job_valid),
		.job       (f_job),
		.job_ready (f_job_ready)
	);

	// lets the front end run ahead while a long remainder is in flight
	xrr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_job_valid),
		.in_ready  (f_job_ready),
		.in_job    (f_job),
		.out_valid (b_job_valid),
		.out_ready (b_job_ready),
		.out_job   (b_job)
	);

	xrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_job_valid),
		.job_ready (b_job_ready),
		.job       (b_job),
		.rsp       (rsp)
	);

endmodule

// ===== bench/xrr_result_checker.sv =====
// Result checker for the xorshift range random core: predicts each result
// beat from the request beats and seed writes it sees. Uses xrr_pkg, xrr_if.
`timescale 1ns / 1ps

module xrr_result_checker (
	input  logic           clk,
	input  logic           arst_n,
	xrr_req_if             req,
	xrr_rsp_if             rsp,
	input  logic           cfg_we,
	input  xrr_pkg::word_t cfg_wdata,
	output int             mismatches,
	output int             outstanding
);
	import xrr_pkg::*;

	word_t seed_reg;
	word_t gen_state;
	logic  seeded;
	word_t expected_values[$];
	int    error_total;

	// First advance after reset loads the seed as is, later ones scramble.
	function automatic void advance_generator();
		word_t s;
		if (!seeded) begin
			gen_state = seed_reg;
			seeded = 1'b1;
			return;
		end
		s = gen_state;
		s = s ^ (s >> 5);
		s = s ^ (s << 10);
		s = s ^ (s >> 17);
		s = s ^ (s << 3);
		s = s ^ (s >> 12);
		s = s ^ (s << 9);
		s = s ^ (s >> 8);
		gen_state = s;
	endfunction

	function automatic word_t fold_into(word_t base, word_t hi_v, word_t n);
		word_t span;
		span = hi_v - base + word_t'(1);
		if (span == '0)
			return n;
		return base + n % span;
	endfunction

	function automatic word_t draw_in_range(word_t a, word_t b);
		advance_generator();
		if (a > b) begin
			advance_generator();
			return fold_into(b, a, gen_state);
		end
		if (a == b)
			return b;
		return fold_into(a, b, gen_state);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			seed_reg = SEED_RESET;
			gen_state = '0;
			seeded = 1'b0;
			expected_values.delete();
			error_total = 0;
		end else begin
			if (cfg_we)
				seed_reg = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (expected_values.size() == 0) begin
					$error("unexpected result beat: random_value %h", rsp.random_value);
					error_total++;
				end else begin
					want = expected_values.pop_front();
					if (rsp.random_value !== want) begin
						$error("random_value mismatch: expected %h, actual %h",
							want, rsp.random_value);
						error_total++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_values.push_back(draw_in_range(req.low_bound, req.high_bound));
		end
		mismatches <= error_total;
		outstanding <= expected_values.size();
	end

endmodule

// ===== bench/xorshift_range_random_core_test.sv =====
// Top of the xorshift range random core test: clock, reset, seed writes,
// request stimulus, result stalls and verdict. Uses xrr_pkg, xrr_if, checker.
`timescale 1ns / 1ps

module xorshift_range_random_core_test;
	import xrr_pkg::*;

	localparam int    RESET_CYCLES = 5;
	localparam int    PHASES       = 4;
	localparam int    PHASE_BEATS  = 133;
	localparam int    IDLE_LIMIT   = 3000;  // cycles with no beat on either side
	localparam int    TAIL_CYCLES  = 150;   // > one full ranged result plus front end
	localparam word_t ALL_ONES     = '1;
	localparam word_t TOP_BIT      = word_t'(1) << (WORD_W - 1);

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	word_t cfg_wdata;
	logic  no_stall;       // set for one phase: both sides run flat out
	int    mismatches;
	int    outstanding;
	int    idle_cycles = 0;

	xrr_req_if req_ch();
	xrr_rsp_if rsp_ch();

	xorshift_range_random_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	xrr_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap length shared by sender and receiver: mostly none or short,
	// now and then long enough to back the job queue up or drain it.
	function automatic int pick_gap();
		int roll;
		if (no_stall)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// Receiver: ready drops for a random number of cycles after each
	// ready cycle, so stalls land on every phase of the back end.
	initial begin
		int stall_left;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no beat.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("xorshift_range_random_core_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// One request beat. Valid stays high across back-to-back beats; this task
	// only drops it when a gap is picked, so it never toggles within one time step.
	task automatic send_bounds(input word_t lo, input word_t hi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.low_bound  <= lo;
		req_ch.high_bound <= hi;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Seed write; the wait with cfg_we low afterwards keeps consecutive writes in separate steps.
	task automatic write_seed(input word_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Every request yields a result, so an empty expectation queue means
	// the core is idle. The first edge lets the last push show up.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random request mix: equal, swapped, full range, narrow spans near
	// random bases (both orders) and fully random pairs.
	task automatic send_random_request();
		word_t a, b, t;
		int    roll;
		roll = $urandom_range(0, 99);
		a = rand_word();
		b = rand_word();
		if (roll < 20) begin
			send_bounds(a, a);
		end else if (roll < 40) begin
			if (a < b) begin
				t = a;
				a = b;
				b = t;
			end
			send_bounds(a, b);
		end else if (roll < 46) begin
			if ($urandom_range(0, 1))
				send_bounds('0, ALL_ONES);
			else
				send_bounds(ALL_ONES, '0);
		end else if (roll < 72) begin
			b = a + word_t'($urandom_range(1, 300));
			if ($urandom_range(0, 1))
				send_bounds(a, b);
			else
				send_bounds(b, a);
		end else begin
			send_bounds(a, b);
		end
	endtask

	initial begin
		word_t seed;
		arst_n             = 1'b0;
		no_stall           = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.low_bound   = '0;
		req_ch.high_bound  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed register sees both extremes before the first request;
		// the last write, nonzero so the generator moves, is the one loaded.
		write_seed('0);
		write_seed(ALL_ONES);
		seed = rand_word();
		if (seed == '0)
			seed = SEED_RESET;
		write_seed(seed);

		// Directed: first request loads the seed, then bound extremes,
		// full range in both orders, swapped and adjacent bounds.
		send_bounds('0, '0);
		send_bounds(ALL_ONES, ALL_ONES);
		send_bounds('0, ALL_ONES);
		send_bounds(ALL_ONES, '0);
		send_bounds(word_t'(1), '0);
		send_bounds('0, word_t'(1));
		send_bounds(ALL_ONES - 1, ALL_ONES);
		send_bounds(ALL_ONES, ALL_ONES - 1);
		send_bounds('0, TOP_BIT);
		send_bounds(TOP_BIT, TOP_BIT - 1);
		send_bounds(TOP_BIT - 1, TOP_BIT);
		send_bounds(word_t'(123), word_t'(456));
		send_bounds(word_t'(456), word_t'(123));
		send_bounds(word_t'(1000), word_t'(1000));
		send_bounds('0, word_t'(2));
		send_bounds(word_t'(7), ALL_ONES);
		send_bounds(ALL_ONES, word_t'(7));
		send_bounds(rand_word(), rand_word());
		drain_results();

		// Random phases; seed writes in between must not disturb the
		// already seeded generator. Phase 2 runs with no idling at all.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: begin
					write_seed('0);
				end
				2: begin
					write_seed(ALL_ONES);
				end
				3: begin
					write_seed(rand_word());
				end
				default: begin
				end
			endcase
			no_stall = (phase == 2);
			repeat (PHASE_BEATS) send_random_request();
			drain_results();
		end

		no_stall = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("xorshift_range_random_core_test: PASS");
		else
			$display("xorshift_range_random_core_test: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/xrr_pkg.sv
rtl/xrr_if.sv
rtl/xrr_front.sv
rtl/xrr_queue.sv
rtl/xrr_back.sv
rtl/xorshift_range_random_core.sv
bench/xrr_result_checker.sv
bench/xorshift_range_random_core_test.sv
